@@ rtl/core/rcs_pkg.sv @@
// rotating card stack: shared types and codes
// no dependencies; imported by rotating_card_stack
`timescale 1ns / 1ps

package rcs_pkg;

  localparam int unsigned CardW = 16;

  typedef enum logic [1:0] {
    OP_PUSH          = 2'd0,
    OP_POP           = 2'd1,
    OP_TOP_TO_BOTTOM = 2'd2,
    OP_BOTTOM_TO_TOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

endpackage

@@ rtl/core/rotating_card_stack.sv @@
// rotating card stack: bounded stack of card ids in a ring buffer memory
// depends on rcs_pkg
`timescale 1ns / 1ps

// A bounded stack of 16-bit card ids kept in a DEPTH-entry ring buffer held in
// one synchronous memory (one write port, one registered read port). Each input
// transfer carries push, pop, top-to-bottom or bottom-to-top and gives exactly
// one result: status, popped id (pop only, else zero) and cards held afterward.
// A push, or any operation that is refused (empty or full), finishes in the
// cycle it is taken, so these run at one per cycle while results drain. Pop and
// both rotations need the memory read first; the read state then writes back
// (rotations only) and moves the pointers. A result waits in a staging register
// ahead of the output register, so the next item is taken while a result is not
// yet collected. The store needs no clearing after reset.
module rotating_card_stack
  import rcs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [CardW-1:0]             in_card_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CardW-1:0]             out_card_out,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_cards_held
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LastSlot) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? LastSlot : s - AW'(1);
  endfunction

  logic [CardW-1:0] mem [DEPTH];

  fsm_t             state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic [AW-1:0]    bot_r, bot_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic             res_valid_r, res_valid_nxt;
  logic [CardW-1:0] res_card_r, res_card_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [CW-1:0]    res_cnt_r, res_cnt_nxt;

  logic             out_valid_r;
  logic [CardW-1:0] out_card_r;
  status_t          out_status_r;
  logic [CW-1:0]    out_cnt_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CardW-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [CardW-1:0] rd_data_r;

  logic out_load;
  logic in_xfer;

  // staging register moves to the output register whenever that one is free
  assign out_load = res_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) && (!res_valid_r || out_load);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    top_nxt        = top_r;
    bot_nxt        = bot_r;
    cnt_nxt        = cnt_r;
    res_valid_nxt  = res_valid_r && !out_load;
    res_card_nxt   = res_card_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = top_r;
    wr_data        = in_card_in;
    rd_addr        = slot_dec(top_r);

    case (state_r)
      S_IDLE: begin
        op_nxt = op_t'(in_operation);
        if (op_t'(in_operation) == OP_BOTTOM_TO_TOP) begin
          rd_addr = bot_r;
        end
        if (in_xfer) begin
          res_card_nxt   = '0;
          res_status_nxt = ST_DONE;
          res_cnt_nxt    = cnt_r;
          if (op_t'(in_operation) == OP_PUSH) begin
            res_valid_nxt = 1'b1;
            if (cnt_r == FullCnt) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              top_nxt     = slot_inc(top_r);
              cnt_nxt     = cnt_r + CW'(1);
              res_cnt_nxt = cnt_r + CW'(1);
            end
          end else if (cnt_r == '0) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = ST_EMPTY;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // read data of the entry addressed at the transfer is now valid
        state_nxt      = S_IDLE;
        res_valid_nxt  = 1'b1;
        res_card_nxt   = '0;
        res_status_nxt = ST_DONE;
        res_cnt_nxt    = cnt_r;
        wr_data        = rd_data_r;
        case (op_r)
          OP_POP: begin
            top_nxt      = slot_dec(top_r);
            cnt_nxt      = cnt_r - CW'(1);
            res_cnt_nxt  = cnt_r - CW'(1);
            res_card_nxt = rd_data_r;
          end
          OP_TOP_TO_BOTTOM: begin
            top_nxt = slot_dec(top_r);
            bot_nxt = slot_dec(bot_r);
            wr_en   = 1'b1;
            wr_addr = slot_dec(bot_r);
          end
          OP_BOTTOM_TO_TOP: begin
            top_nxt = slot_inc(top_r);
            bot_nxt = slot_inc(bot_r);
            wr_en   = 1'b1;
            wr_addr = top_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      bot_r       <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    res_card_r   <= res_card_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if (out_load) begin
      out_card_r   <= res_card_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_card_out   = out_card_r;
  assign out_status     = out_status_r;
  assign out_cards_held = out_cnt_r;

endmodule

@@ test/tb_rotating_card_stack.sv @@
// testbench for rotating_card_stack: directed table plus burst-shaped random traffic,
// every result checked against the table's fixed result or an in-bench stack predictor
// depends on rcs_pkg and rotating_card_stack
`timescale 1ns / 1ps

module tb_rotating_card_stack;
  import rcs_pkg::*;

  localparam int DEPTH = 64;
  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 585;

  typedef struct {
    logic [CardW-1:0]  card;
    status_t           status;
    logic [HELD_W-1:0] held;
  } stack_result_t;

  typedef struct {
    op_t           op;
    logic [15:0]   card;
    int            reps;
    bit            fixed;
    stack_result_t result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = 2'd0;
  logic [CardW-1:0] in_card_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CardW-1:0] out_card_out;
  logic [1:0] out_status;
  logic [HELD_W-1:0] out_cards_held;

  // predictor state: ring of card ids, bottom index, next-push index, count
  logic [CardW-1:0] deck [DEPTH];
  int deck_bottom = 0;
  int deck_top = 0;
  int deck_size = 0;

  stack_result_t awaited_results[$];
  plan_row_t plan[$];

  // typed expectation for the item currently offered, when the table gives one
  bit fixed_pending = 1'b0;
  stack_result_t fixed_result;

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit holdoff_req = 1'b0;

  rotating_card_stack #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_card_in     (in_card_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_card_out   (out_card_out),
    .out_status     (out_status),
    .out_cards_held (out_cards_held)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** rotating_card_stack: FAILED **");
    $finish;
  end

  function automatic int slot_next(int s);
    return (s == DEPTH - 1) ? 0 : s + 1;
  endfunction

  function automatic int slot_prev(int s);
    return (s == 0) ? DEPTH - 1 : s - 1;
  endfunction

  function automatic stack_result_t stack_apply(op_t op, logic [CardW-1:0] card);
    stack_result_t r;
    logic [CardW-1:0] moved;
    r.card = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (deck_size >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        deck[deck_top] = card;
        deck_top = slot_next(deck_top);
        deck_size++;
      end
    end else if (deck_size == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_POP) begin
      deck_top = slot_prev(deck_top);
      r.card = deck[deck_top];
      deck_size--;
    end else if (op == OP_TOP_TO_BOTTOM) begin
      deck_top = slot_prev(deck_top);
      moved = deck[deck_top];
      deck_bottom = slot_prev(deck_bottom);
      deck[deck_bottom] = moved;
    end else begin
      // with one card the card just moves up one slot: no visible change
      moved = deck[deck_bottom];
      deck_bottom = slot_next(deck_bottom);
      deck[deck_top] = moved;
      deck_top = slot_next(deck_top);
    end
    r.held = HELD_W'(deck_size);
    return r;
  endfunction

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk) begin : track
    stack_result_t predicted;
    stack_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = stack_apply(op_t'(in_operation), in_card_in);
        if (fixed_pending) begin
          awaited_results.push_back(fixed_result);
        end else begin
          awaited_results.push_back(predicted);
        end
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: card %h status %0d held %0d",
                     out_card_out, out_status, out_cards_held);
        end else begin
          want = awaited_results.pop_front();
          if (out_card_out !== want.card || out_status !== want.status ||
              out_cards_held !== want.held) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp card %h st %0d held %0d, got card %h st %0d held %0d",
                       want.card, want.status, want.held,
                       out_card_out, out_status, out_cards_held);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request to back up the block
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        repeat (HOLDOFF_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(op_t op, logic [CardW-1:0] card, bit fixed, stack_result_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    fixed_pending = fixed;
    fixed_result = r;
    in_valid <= 1'b1;
    in_operation <= op;
    in_card_in <= card;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    fixed_pending = 1'b0;
  endtask

  task automatic plan_row(op_t op, logic [15:0] card, int reps, bit fixed,
                          logic [15:0] card_out, status_t st, int held);
    plan_row_t row;
    row.op = op;
    row.card = card;
    row.reps = reps;
    row.fixed = fixed;
    row.result.card = card_out;
    row.result.status = st;
    row.result.held = HELD_W'(held);
    plan.push_back(row);
  endtask

  function automatic op_t pick_op(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: return (roll < 75) ? OP_PUSH : (roll < 85) ? OP_POP :
                (roll < 93) ? OP_TOP_TO_BOTTOM : OP_BOTTOM_TO_TOP;
      1: return (roll < 70) ? OP_POP : (roll < 85) ? OP_PUSH :
                (roll < 93) ? OP_TOP_TO_BOTTOM : OP_BOTTOM_TO_TOP;
      2: return (roll < 35) ? OP_TOP_TO_BOTTOM : (roll < 70) ? OP_BOTTOM_TO_TOP :
                (roll < 85) ? OP_PUSH : OP_POP;
      default: return op_t'($urandom_range(0, 3));
    endcase
  endfunction

  // bursts of fill, drain, rotate and mixed traffic so the stack swings empty to full
  task automatic run_random(int count);
    stack_result_t none;
    int mode;
    int burst;
    int pick;
    logic [CardW-1:0] card;
    none = '{card: '0, status: ST_DONE, held: '0};
    while (count > 0) begin
      mode = $urandom_range(0, 3);
      burst = $urandom_range(40, 150);
      for (int i = 0; i < burst && count > 0; i++) begin
        pick = $urandom_range(0, 9);
        card = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff :
               CardW'($urandom_range(0, 65535));
        send_item(pick_op(mode), card, 1'b0, none);
        count--;
      end
    end
  endtask

  initial begin
    plan_row(OP_POP,           16'h0000, 1,  1, 16'h0000, ST_EMPTY, 0);
    plan_row(OP_TOP_TO_BOTTOM, 16'h0000, 1,  1, 16'h0000, ST_EMPTY, 0);
    plan_row(OP_BOTTOM_TO_TOP, 16'hffff, 1,  1, 16'h0000, ST_EMPTY, 0);
    plan_row(OP_PUSH,          16'hffff, 1,  1, 16'h0000, ST_DONE,  1);
    plan_row(OP_TOP_TO_BOTTOM, 16'h0000, 1,  1, 16'h0000, ST_DONE,  1);
    plan_row(OP_BOTTOM_TO_TOP, 16'h0000, 1,  1, 16'h0000, ST_DONE,  1);
    plan_row(OP_POP,           16'h0000, 1,  1, 16'hffff, ST_DONE,  0);
    plan_row(OP_PUSH,          16'h0000, 1,  1, 16'h0000, ST_DONE,  1);
    plan_row(OP_PUSH,          16'haaaa, 1,  1, 16'h0000, ST_DONE,  2);
    plan_row(OP_PUSH,          16'h5555, 1,  1, 16'h0000, ST_DONE,  3);
    plan_row(OP_TOP_TO_BOTTOM, 16'h0000, 1,  1, 16'h0000, ST_DONE,  3);
    plan_row(OP_POP,           16'h0000, 1,  0, 16'h0000, ST_DONE,  0);
    plan_row(OP_BOTTOM_TO_TOP, 16'h0000, 1,  0, 16'h0000, ST_DONE,  0);
    plan_row(OP_POP,           16'h0000, 1,  0, 16'h0000, ST_DONE,  0);
    plan_row(OP_PUSH,          16'h1000, 62, 0, 16'h0000, ST_DONE,  0);
    plan_row(OP_PUSH,          16'hffff, 1,  1, 16'h0000, ST_DONE,  64);
    plan_row(OP_PUSH,          16'h1234, 1,  1, 16'h0000, ST_FULL,  64);
    plan_row(OP_TOP_TO_BOTTOM, 16'h0000, 1,  1, 16'h0000, ST_DONE,  64);
    plan_row(OP_BOTTOM_TO_TOP, 16'h0000, 1,  1, 16'h0000, ST_DONE,  64);
    plan_row(OP_POP,           16'h0000, 1,  1, 16'hffff, ST_DONE,  63);
    plan_row(OP_PUSH,          16'hfffe, 1,  0, 16'h0000, ST_DONE,  0);
    plan_row(OP_PUSH,          16'h0000, 1,  1, 16'h0000, ST_FULL,  64);
    plan_row(OP_POP,           16'h0000, 64, 0, 16'h0000, ST_DONE,  0);
    plan_row(OP_POP,           16'h0000, 1,  1, 16'h0000, ST_EMPTY, 0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 76;
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++)
        send_item(plan[i].op, plan[i].card + k[15:0], plan[i].fixed, plan[i].result);
    end

    holdoff_req = 1'b1;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 76;
    recv_idle_pct = 18;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_req = 1'b1;
    run_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** rotating_card_stack: PASSED **");
    end else begin
      $display("** rotating_card_stack: FAILED **");
    end
    $finish;
  end

endmodule
